>>> rtl/ese_pkg.sv
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants for the encoder speed estimator
// Field widths, register reset values, register indexes and the
// command/status structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ese_pkg;

    // Fixed field widths
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;
    localparam int SPEED_W = 32;
    localparam int DIST_W  = 48;
    localparam int SCALE_W = 24;
    localparam int ALPHA_W = 17;
    localparam int PERIOD_W = 16;

    // Default number of fraction bits in fixed-point values
    localparam int FRAC_BITS_DEF = 16;

    // Register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_REVERSE     = 2'd0;
    localparam logic [1:0] REG_SPEED_SCALE = 2'd1;
    localparam logic [1:0] REG_ALPHA       = 2'd2;
    localparam logic [1:0] REG_PERIOD      = 2'd3;

    localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd65536;
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 17'd19661;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd655;

    typedef struct packed {
        logic                reverse;
        logic [SCALE_W-1:0]  speed_scale;
        logic [ALPHA_W-1:0]  alpha;
        logic [PERIOD_W-1:0] period;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load_in;    // capture corrected count, bump total
        logic mul_raw;    // raw speed = count * scale
        logic mul_filt;   // low-pass update of speed
        logic mul_dist;   // distance += period * speed
        logic load_out;   // fill output register
        logic out_fresh;  // output distance from this cycle's update
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a new result
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/ese_in_if.sv
// ----------------------------------------------------------------------------
// ese_in_if: input channel of the encoder speed estimator
// One transaction carries one sampling period's raw encoder count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ese_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_count;

    modport source (output valid, output raw_count, input ready);
    modport sink   (input valid, input raw_count, output ready);
endinterface

`default_nettype wire

>>> rtl/ese_out_if.sv
// ----------------------------------------------------------------------------
// ese_out_if: result channel of the encoder speed estimator
// One transaction carries the corrected count, total, speed and distance.
// ----------------------------------------------------------------------------
`default_nettype none

interface ese_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] signed_count;
    logic signed [31:0] total;
    logic signed [31:0] speed;
    logic signed [47:0] distance_cm;

    modport source (output valid, output signed_count, output total,
                    output speed, output distance_cm, input ready);
    modport sink   (input valid, input signed_count, input total,
                    input speed, input distance_cm, output ready);
endinterface

`default_nettype wire

>>> rtl/ese_regs.sv
// ----------------------------------------------------------------------------
// ese_regs: APB configuration registers
// Holds reverse, speed_scale, alpha and period; zero-wait-state access.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [ese_pkg::PADDR_W-1:0]   paddr,
    input  wire [ese_pkg::PDATA_W-1:0]   pwdata,
    output logic [ese_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output ese_pkg::t_cfg                o_cfg
);
    import ese_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse     <= 1'b0;
            r_cfg.speed_scale <= SCALE_RST;
            r_cfg.alpha       <= ALPHA_RST;
            r_cfg.period      <= PERIOD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_REVERSE:     r_cfg.reverse     <= pwdata[0];
                REG_SPEED_SCALE: r_cfg.speed_scale <= pwdata[SCALE_W-1:0];
                REG_ALPHA:       r_cfg.alpha       <= pwdata[ALPHA_W-1:0];
                REG_PERIOD:      r_cfg.period      <= pwdata[PERIOD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_REVERSE:     prdata = {{(PDATA_W-1){1'b0}}, r_cfg.reverse};
            REG_SPEED_SCALE: prdata = {{(PDATA_W-SCALE_W){1'b0}}, r_cfg.speed_scale};
            REG_ALPHA:       prdata = {{(PDATA_W-ALPHA_W){1'b0}}, r_cfg.alpha};
            REG_PERIOD:      prdata = {{(PDATA_W-PERIOD_W){1'b0}}, r_cfg.period};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ese_ctrl.sv
// ----------------------------------------------------------------------------
// ese_ctrl: sequencer of the encoder speed estimator
// Steps one item through the three products of the shared multiplier and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  ese_pkg::t_dp_sts  i_sts,
    output ese_pkg::t_dp_cmd  o_cmd
);
    import ese_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RAW  = 5'b00010,
        S_FILT = 5'b00100,
        S_DIST = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_RAW;
                end
            end
            S_RAW: begin
                o_cmd.mul_raw = 1'b1;
                n_state       = S_FILT;
            end
            S_FILT: begin
                o_cmd.mul_filt = 1'b1;
                n_state        = S_DIST;
            end
            S_DIST: begin
                o_cmd.mul_dist = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.out_fresh = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Checks
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_in, o_cmd.mul_raw, o_cmd.mul_filt, o_cmd.mul_dist}))
        else $error("ese_ctrl: more than one datapath step at once");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_cmd.mul_raw ##1 o_cmd.mul_filt)
        else $error("ese_ctrl: accepted transaction not sequenced");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("ese_ctrl: output loaded while still occupied");

endmodule

`default_nettype wire

>>> rtl/ese_dp.sv
// ----------------------------------------------------------------------------
// ese_dp: datapath of the encoder speed estimator
// Direction correction, running total, one shared signed multiplier for
// raw speed, low-pass filter and distance, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_dp #(
    parameter int FRAC_BITS = ese_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ese_pkg::t_cfg                i_cfg,
    input  ese_pkg::t_dp_cmd             i_cmd,
    output ese_pkg::t_dp_sts             o_sts,
    input  wire signed [15:0]            i_raw_count,
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output logic signed [15:0]           o_signed_count,
    output logic signed [31:0]           o_total,
    output logic signed [31:0]           o_speed,
    output logic signed [47:0]           o_distance_cm
);
    import ese_pkg::*;

    // Multiplier sizing: A is the signed 33-bit filter difference plus a
    // sign bit, B the largest unsigned operand (scale, or alpha up to 1.0).
    localparam int MA_W = SPEED_W + 2;
    localparam int MB_W = (FRAC_BITS + 1 > SCALE_W) ? FRAC_BITS + 1 : SCALE_W;
    localparam int P_W  = MA_W + MB_W + 1;
    localparam int S_W  = P_W + 1;

    localparam logic [MB_W-1:0]        ONE  = MB_W'(1) << FRAC_BITS;
    localparam logic signed [S_W-1:0]  HALF = S_W'(1) << (FRAC_BITS - 1);

    localparam logic signed [SPEED_W-1:0] S32_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] S32_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic signed [DIST_W-1:0]  S48_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0]  S48_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    logic signed [COUNT_W-1:0] r_count;
    logic signed [TOTAL_W-1:0] r_total;
    logic signed [SPEED_W-1:0] r_raw;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [DIST_W-1:0]  r_dist;
    logic                      r_o_valid;
    logic signed [COUNT_W-1:0] r_o_count;
    logic signed [TOTAL_W-1:0] r_o_total;
    logic signed [SPEED_W-1:0] r_o_speed;
    logic signed [DIST_W-1:0]  r_o_dist;

    logic signed [COUNT_W-1:0] cnt_fix;
    logic [MB_W-1:0]           alpha_eff;
    logic signed [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]           mul_b;
    logic signed [P_W-1:0]     mul_p;
    logic signed [S_W-1:0]     p_ext;
    logic signed [SPEED_W-1:0] raw_sat;
    logic signed [S_W-1:0]     f_sum;
    logic signed [S_W-1:0]     f_shift;
    logic signed [SPEED_W-1:0] spd_sat;
    logic signed [S_W-1:0]     d_step;
    logic signed [S_W-1:0]     d_sum;
    logic signed [DIST_W-1:0]  n_dist;

    // Direction correction; negating the minimum count saturates
    always_comb begin
        if (!i_cfg.reverse) begin
            cnt_fix = i_raw_count;
        end else if (i_raw_count == {1'b1, {(COUNT_W-1){1'b0}}}) begin
            cnt_fix = {1'b0, {(COUNT_W-1){1'b1}}};
        end else begin
            cnt_fix = -i_raw_count;
        end
    end

    // Alpha above one acts as exactly one
    assign alpha_eff = (MB_W'(i_cfg.alpha) > ONE) ? ONE : MB_W'(i_cfg.alpha);

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_raw) begin
            mul_a = MA_W'(r_count);
            mul_b = MB_W'(i_cfg.speed_scale);
        end else if (i_cmd.mul_filt) begin
            // a*raw + (1-a)*y == y*one + a*(raw - y)
            mul_a = MA_W'($signed({r_raw[SPEED_W-1], r_raw})
                        - $signed({r_speed[SPEED_W-1], r_speed}));
            mul_b = alpha_eff;
        end else if (i_cmd.mul_dist) begin
            mul_a = MA_W'(r_speed);
            mul_b = MB_W'(i_cfg.period);
        end
    end

    assign mul_p = P_W'(mul_a) * P_W'($signed({1'b0, mul_b}));
    assign p_ext = {mul_p[P_W-1], mul_p};

    // Raw speed, saturated to 32 bits
    always_comb begin
        if ((&mul_p[P_W-1:SPEED_W-1]) || !(|mul_p[P_W-1:SPEED_W-1])) begin
            raw_sat = mul_p[SPEED_W-1:0];
        end else begin
            raw_sat = mul_p[P_W-1] ? S32_MIN : S32_MAX;
        end
    end

    // Filter update, round half up, saturate
    assign f_sum   = ({{(S_W-SPEED_W){r_speed[SPEED_W-1]}}, r_speed} <<< FRAC_BITS) + p_ext;
    assign f_shift = (f_sum + HALF) >>> FRAC_BITS;

    always_comb begin
        if ((&f_shift[S_W-1:SPEED_W-1]) || !(|f_shift[S_W-1:SPEED_W-1])) begin
            spd_sat = f_shift[SPEED_W-1:0];
        end else begin
            spd_sat = f_shift[S_W-1] ? S32_MIN : S32_MAX;
        end
    end

    // Distance step and saturating accumulate
    assign d_step = (p_ext + HALF) >>> FRAC_BITS;
    assign d_sum  = {{(S_W-DIST_W){r_dist[DIST_W-1]}}, r_dist} + d_step;

    always_comb begin
        if ((&d_sum[S_W-1:DIST_W-1]) || !(|d_sum[S_W-1:DIST_W-1])) begin
            n_dist = d_sum[DIST_W-1:0];
        end else begin
            n_dist = d_sum[S_W-1] ? S48_MIN : S48_MAX;
        end
    end

    // Working state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_speed <= '0;
            r_dist  <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_total <= r_total + TOTAL_W'(cnt_fix);
            end
            if (i_cmd.mul_filt) begin
                r_speed <= spd_sat;
            end
            if (i_cmd.mul_dist) begin
                r_dist <= n_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_count <= cnt_fix;
        end
        if (i_cmd.mul_raw) begin
            r_raw <= raw_sat;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_count <= r_count;
            r_o_total <= r_total;
            r_o_speed <= r_speed;
            r_o_dist  <= i_cmd.out_fresh ? n_dist : r_dist;
        end
    end

    assign o_sts.out_free = !r_o_valid || i_out_ready;
    assign o_out_valid    = r_o_valid;
    assign o_signed_count = r_o_count;
    assign o_total        = r_o_total;
    assign o_speed        = r_o_speed;
    assign o_distance_cm  = r_o_dist;

    // Checks
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.load_in |=> $stable(r_total))
        else $error("ese_dp: total changed without a new count");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (o_out_valid && o_speed == r_speed))
        else $error("ese_dp: output register not loaded");

    a_fresh_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && i_cmd.out_fresh) |=> (o_distance_cm == r_dist))
        else $error("ese_dp: output distance differs from accumulator");

endmodule

`default_nettype wire

>>> rtl/encoder_speed_estimator.sv
// ----------------------------------------------------------------------------
// encoder_speed_estimator: quadrature encoder speed and distance estimator
// Usage:
//   i_in carries one raw encoder count per sampling period; o_out returns
//   one transaction per input: corrected count, running total, low-pass
//   filtered speed (Q16.FRAC_BITS) and integrated distance (Q32.FRAC_BITS).
//   Both channels use valid/ready; a transaction moves when both are high.
//   The APB port writes reverse, speed_scale, alpha and period at byte
//   addresses 0, 4, 8 and 12; write only while no transaction is in flight.
// Timing:
//   Each transaction passes the accept step, then raw speed, filter
//   update and distance on a single shared multiplier; the next one is
//   accepted only after this result has entered the output register.
//   i_in.ready is high only while no transaction is being processed.
// Stall:
//   A result waits in the output register while o_out.ready is low; the
//   sequencer holds the next result until that register frees.
// Reset:
//   i_rst_n (synchronous, low) clears total, speed and distance and loads
//   the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_estimator #(
    parameter int FRAC_BITS = ese_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    ese_in_if.sink                       i_in,
    ese_out_if.source                    o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [ese_pkg::PADDR_W-1:0]   paddr,
    input  wire [ese_pkg::PDATA_W-1:0]   pwdata,
    output logic [ese_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import ese_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration registers
    ese_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    ese_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and output register
    ese_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_raw_count    (i_in.raw_count),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_signed_count (o_out.signed_count),
        .o_total        (o_out.total),
        .o_speed        (o_out.speed),
        .o_distance_cm  (o_out.distance_cm)
    );

endmodule

`default_nettype wire
